// File: hw/rtl/sat_pkg.sv
// Shared constants, codes and types of the section address translator.
package sat_pkg;

  // Table geometry
  localparam int MAX_SECTIONS = 16;
  localparam int SEC_IDX_W    = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int SEC_CNT_W    = $clog2(MAX_SECTIONS + 1);

  // Field widths
  localparam int ADDR_W      = 32;
  localparam int OP_W        = 2;
  localparam int ENTRY_IDX_W = 4;
  localparam int COUNT_W     = 5;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 32;

  // Operation codes
  localparam logic [OP_W-1:0] OP_WRITE       = 2'd0;
  localparam logic [OP_W-1:0] OP_MEM_TO_FILE = 2'd1;
  localparam logic [OP_W-1:0] OP_FILE_TO_MEM = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE        = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SIZE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECTION_COUNT = 4'd1;

  localparam logic [ADDR_W-1:0]  HEADER_SIZE_RESET   = 32'd1024;
  localparam logic [COUNT_W-1:0] SECTION_COUNT_RESET = 5'd0;

  // One section table entry
  typedef struct packed {
    logic [ADDR_W-1:0] mem_address;
    logic [ADDR_W-1:0] virtual_size;
    logic [ADDR_W-1:0] raw_size;
    logic [ADDR_W-1:0] file_offset;
  } sec_entry_t;

  // Controller to datapath
  typedef struct packed {
    logic write_entry;   // store the request's entry
    logic start_search;  // latch query, direction and entry count
    logic pend_fixed;    // result is the query itself, hit
    logic pend_miss;     // result is zero, no hit
    logic pend_match;    // result is the stage-two sum, hit
    logic issue;         // read the next table entry
    logic flush;         // drop entries still in flight
    logic out_load;      // move pending result to the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic query_fixed;   // incoming query at or below header size
    logic count_zero;    // no entries to search
    logic issued_all;    // every active entry has been read
    logic rd_valid;      // read data stage holds an entry
    logic s1_valid;      // compare stage holds an entry
    logic s1_match;      // compare stage entry matches
    logic s1_last;       // compare stage entry is the last active one
    logic out_free;      // output register can take a result this cycle
  } dp_status_t;

endpackage

// File: hw/rtl/sat_if.sv
// Handshake channel interfaces: translation requests, results, configuration writes.
interface sat_in_if;
  logic                            valid;
  logic                            ready;
  logic [sat_pkg::OP_W-1:0]        operation;
  logic [sat_pkg::ENTRY_IDX_W-1:0] entry_index;
  logic [sat_pkg::ADDR_W-1:0]      entry_mem_address;
  logic [sat_pkg::ADDR_W-1:0]      entry_virtual_size;
  logic [sat_pkg::ADDR_W-1:0]      entry_raw_size;
  logic [sat_pkg::ADDR_W-1:0]      entry_file_offset;
  logic [sat_pkg::ADDR_W-1:0]      query_address;

  modport source (
    output valid, operation, entry_index, entry_mem_address, entry_virtual_size,
           entry_raw_size, entry_file_offset, query_address,
    input  ready
  );
  modport sink (
    input  valid, operation, entry_index, entry_mem_address, entry_virtual_size,
           entry_raw_size, entry_file_offset, query_address,
    output ready
  );
endinterface

interface sat_out_if;
  logic                       valid;
  logic                       ready;
  logic [sat_pkg::ADDR_W-1:0] mapped_address;
  logic                       hit;

  modport source (output valid, mapped_address, hit, input ready);
  modport sink   (input valid, mapped_address, hit, output ready);
endinterface

interface sat_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sat_pkg::CFG_IDX_W-1:0]  index;
  logic [sat_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/sat_datapath.sv
// Datapath: config registers, section table, two-stage entry compare, result registers.
module sat_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  // request payload
  input  logic [sat_pkg::ENTRY_IDX_W-1:0] in_entry_index,
  input  logic [sat_pkg::OP_W-1:0]        in_operation,
  input  logic [sat_pkg::ADDR_W-1:0]      in_entry_mem_address,
  input  logic [sat_pkg::ADDR_W-1:0]      in_entry_virtual_size,
  input  logic [sat_pkg::ADDR_W-1:0]      in_entry_raw_size,
  input  logic [sat_pkg::ADDR_W-1:0]      in_entry_file_offset,
  input  logic [sat_pkg::ADDR_W-1:0]      in_query_address,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sat_pkg::ADDR_W-1:0]      out_mapped_address,
  output logic                            out_hit,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sat_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sat_pkg::CFG_DATA_W-1:0]  cfg_data,
  // controller
  input  sat_pkg::dp_cmd_t                cmd,
  output sat_pkg::dp_status_t             status
);

  localparam int AW = sat_pkg::ADDR_W;
  localparam int IW = sat_pkg::SEC_IDX_W;
  localparam int CW = sat_pkg::SEC_CNT_W;

  // configuration registers
  logic [AW-1:0]               header_size_r;
  logic [sat_pkg::COUNT_W-1:0] section_count_r;

  // search context
  logic [AW-1:0] query_r;
  logic          f2m_r;      // file to memory direction
  logic [CW-1:0] n_r;        // active entries
  logic [CW-1:0] scan_idx_r;
  logic [CW-1:0] n_nxt;

  // table and pipeline
  sat_pkg::sec_entry_t sec_mem [sat_pkg::MAX_SECTIONS];
  sat_pkg::sec_entry_t rd_data_r;
  logic                rd_vld_r;
  logic                rd_last_r;
  logic                s1_vld_r;
  logic                s1_last_r;
  logic                s1_ge_r;
  logic [AW-1:0]       s1_diff_r;
  logic [AW-1:0]       s1_span_r;
  logic [AW-1:0]       s1_raw_r;
  logic [AW-1:0]       s1_add_r;

  // results
  logic [AW-1:0] pend_addr_r;
  logic          pend_hit_r;
  logic          out_valid_r;
  logic [AW-1:0] out_addr_r;
  logic          out_hit_r;

  // stage one combinational values
  logic [AW-1:0] ref_pt;
  logic [AW-1:0] s1_span_nxt;
  logic          s1_match;
  logic [AW-1:0] s1_sum;
  logic [IW-1:0] wr_addr;
  logic          wr_en;

  assign cfg_ready = 1'b1;

  // configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_size_r   <= sat_pkg::HEADER_SIZE_RESET;
      section_count_r <= sat_pkg::SECTION_COUNT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sat_pkg::REG_HEADER_SIZE:   header_size_r   <= cfg_data;
        sat_pkg::REG_SECTION_COUNT: section_count_r <= cfg_data[sat_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the section count to the table depth
  assign n_nxt = (32'(section_count_r) > 32'(sat_pkg::MAX_SECTIONS)) ?
                 CW'(sat_pkg::MAX_SECTIONS) : CW'(section_count_r);

  // search context and scan counter
  always_ff @(posedge clk) begin
    if (cmd.start_search) begin
      query_r <= in_query_address;
      f2m_r   <= (in_operation == sat_pkg::OP_FILE_TO_MEM);
      n_r     <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
    end else if (cmd.start_search) begin
      scan_idx_r <= '0;
    end else if (cmd.issue) begin
      scan_idx_r <= scan_idx_r + CW'(1);
    end
  end

  // section table: one write port, one registered read port
  assign wr_addr = IW'(in_entry_index);
  assign wr_en   = cmd.write_entry &&
                   (32'(in_entry_index) < 32'(sat_pkg::MAX_SECTIONS));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sec_mem[wr_addr] <= '{mem_address:  in_entry_mem_address,
                            virtual_size: in_entry_virtual_size,
                            raw_size:     in_entry_raw_size,
                            file_offset:  in_entry_file_offset};
    end
    if (cmd.issue) begin
      rd_data_r <= sec_mem[scan_idx_r[IW-1:0]];
      rd_last_r <= (scan_idx_r == (n_r - CW'(1)));
    end
  end

  // stage one: offset into the window, window span
  assign ref_pt      = f2m_r ? rd_data_r.file_offset : rd_data_r.mem_address;
  assign s1_span_nxt = (rd_data_r.raw_size > rd_data_r.virtual_size) ?
                       rd_data_r.raw_size : rd_data_r.virtual_size;

  always_ff @(posedge clk) begin
    s1_ge_r   <= (query_r >= ref_pt);
    s1_diff_r <= query_r - ref_pt;
    s1_span_r <= s1_span_nxt;
    s1_raw_r  <= rd_data_r.raw_size;
    s1_add_r  <= f2m_r ? rd_data_r.mem_address : rd_data_r.file_offset;
    s1_last_r <= rd_last_r;
  end

  // pipeline valids, dropped on flush
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.issue & ~cmd.flush;
      s1_vld_r <= rd_vld_r & ~cmd.flush;
    end
  end

  // stage two: window check and translated address
  // mem->file: diff <= span; file->mem: diff <= raw and diff < span
  assign s1_match = s1_vld_r && s1_ge_r &&
                    (f2m_r ? ((s1_diff_r <= s1_raw_r) && (s1_diff_r < s1_span_r))
                           : (s1_diff_r <= s1_span_r));
  assign s1_sum   = s1_add_r + s1_diff_r;

  // pending result
  always_ff @(posedge clk) begin
    if (cmd.pend_fixed) begin
      pend_addr_r <= in_query_address;
      pend_hit_r  <= 1'b1;
    end else if (cmd.pend_match) begin
      pend_addr_r <= s1_sum;
      pend_hit_r  <= 1'b1;
    end else if (cmd.pend_miss) begin
      pend_addr_r <= '0;
      pend_hit_r  <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_addr_r <= pend_addr_r;
      out_hit_r  <= pend_hit_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_mapped_address = out_addr_r;
  assign out_hit            = out_hit_r;

  // status to the controller
  assign status.query_fixed = (in_query_address <= header_size_r);
  assign status.count_zero  = (section_count_r == '0);
  assign status.issued_all  = (scan_idx_r == n_r);
  assign status.rd_valid    = rd_vld_r;
  assign status.s1_valid    = s1_vld_r;
  assign status.s1_match    = s1_match;
  assign status.s1_last     = s1_last_r;
  assign status.out_free    = ~out_valid_r | out_ready;

endmodule

// File: hw/rtl/sat_controller.sv
// Controller: request decode, entry scan sequencing and result hand-off.
module sat_controller (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [sat_pkg::OP_W-1:0] in_operation,
  input  sat_pkg::dp_status_t      status,
  output sat_pkg::dp_cmd_t         cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid & in_ready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_operation) inside
            sat_pkg::OP_WRITE: begin
              cmd.write_entry = 1'b1;
            end
            sat_pkg::OP_MEM_TO_FILE, sat_pkg::OP_FILE_TO_MEM: begin
              if (status.query_fixed) begin
                cmd.pend_fixed = 1'b1;
                state_nxt      = ST_FIN;
              end else if (status.count_zero) begin
                cmd.pend_miss = 1'b1;
                state_nxt     = ST_FIN;
              end else begin
                cmd.start_search = 1'b1;
                state_nxt        = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // first match wins; entries behind it are dropped
        if (status.s1_match) begin
          cmd.pend_match = 1'b1;
          cmd.flush      = 1'b1;
          state_nxt      = ST_FIN;
        end else if (status.s1_valid && status.s1_last) begin
          cmd.pend_miss = 1'b1;
          cmd.flush     = 1'b1;
          state_nxt     = ST_FIN;
        end else begin
          cmd.issue = ~status.issued_all;
        end
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // result only loaded when the output register can take it
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> status.out_free)
    else $error("result loaded into a full output register");

  // compare pipeline is empty outside a scan
  a_pipe_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (status.s1_valid || status.rd_valid) |-> (state_r == ST_SCAN))
    else $error("entry in flight outside a scan");

  // a scan never stalls with nothing in flight
  a_no_hang: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (!status.issued_all || status.rd_valid || status.s1_valid))
    else $error("scan ran dry without a result");

  // a scan always ends in the result hand-off state
  a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && (status.s1_match || (status.s1_valid && status.s1_last)))
    |=> (state_r == ST_FIN))
    else $error("scan end did not reach result hand-off");

endmodule

// File: hw/rtl/section_address_translator.sv
// Top level of the section address translator: channels, controller and datapath.
//
// Translates addresses between a memory image and its file using a table of up to
// sat_pkg::MAX_SECTIONS section entries. A table write (operation 0) or an unused
// operation code produces no result. A query at or below header_size, or a query with
// section_count zero, delivers its result through the pending result register and then
// the output register. Otherwise entries are read one per cycle from the section table
// memory, in order, through a two-stage compare; the first matching entry gives the
// result, and a miss is reported after the last active entry. The next request is
// accepted once the result sits in the output register, even while it waits to be
// taken. Configuration writes are always ready.
module section_address_translator (
  input  logic          clk,
  input  logic          rst_n,
  sat_in_if.sink        in_ch,
  sat_out_if.source     out_ch,
  sat_cfg_if.sink       cfg_ch
);

  sat_pkg::dp_cmd_t    cmd;
  sat_pkg::dp_status_t status;
  logic                in_ready;
  logic                cfg_ready;
  logic                out_valid;
  logic [sat_pkg::ADDR_W-1:0] out_mapped_address;
  logic                out_hit;

  sat_controller u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ready),
    .in_operation (in_ch.operation),
    .status       (status),
    .cmd          (cmd)
  );

  sat_datapath u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_entry_index        (in_ch.entry_index),
    .in_operation          (in_ch.operation),
    .in_entry_mem_address  (in_ch.entry_mem_address),
    .in_entry_virtual_size (in_ch.entry_virtual_size),
    .in_entry_raw_size     (in_ch.entry_raw_size),
    .in_entry_file_offset  (in_ch.entry_file_offset),
    .in_query_address      (in_ch.query_address),
    .out_valid             (out_valid),
    .out_ready             (out_ch.ready),
    .out_mapped_address    (out_mapped_address),
    .out_hit               (out_hit),
    .cfg_valid             (cfg_ch.valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_ch.index),
    .cfg_data              (cfg_ch.data),
    .cmd                   (cmd),
    .status                (status)
  );

  // channel wiring
  assign in_ch.ready           = in_ready;
  assign cfg_ch.ready          = cfg_ready;
  assign out_ch.valid          = out_valid;
  assign out_ch.mapped_address = out_mapped_address;
  assign out_ch.hit            = out_hit;

endmodule

// File: dv/tb_top.sv
// Testbench for the section address translator: random and directed requests, scoreboarded.
module tb_top;
  import sat_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake at all
  localparam int DRAIN_CYCLES   = 40;    // past the longest search latency
  localparam int LONG_HOLD      = 300;   // receiver hold-off under pressure
  localparam int PHASE_ITEMS    = 160;
  localparam int RANDOM_PHASES  = 12;

  typedef struct packed {
    logic [OP_W-1:0]        operation;
    logic [ENTRY_IDX_W-1:0] entry_index;
    sec_entry_t             entry;
    logic [ADDR_W-1:0]      query_address;
  } sat_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] mapped_address;
    logic              hit;
  } sat_result_t;

  logic clk = 1'b0;
  logic rst_n;

  sat_in_if  in_ch();
  sat_out_if out_ch();
  sat_cfg_if cfg_ch();

  section_address_translator u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the block's registers and section table
  logic [ADDR_W-1:0]  shadow_header_size;
  logic [COUNT_W-1:0] shadow_section_count;
  sec_entry_t         shadow_table [MAX_SECTIONS];

  sat_req_t    pending_reqs[$];
  sat_result_t expected_translations[$];
  int          error_count   = 0;
  int          idle_pct      = 0;
  int          long_hold_req = 0;

  // Table update or address translation for one request; 1 when a result follows
  function automatic bit translate_request(input sat_req_t rq, output sat_result_t res);
    logic [32:0] q, base, off, span, top, r;
    int          n, i;
    bit          found;
    res   = '0;
    found = 1'b0;
    r     = '0;
    q     = {1'b0, rq.query_address};
    n     = (shadow_section_count > MAX_SECTIONS) ? MAX_SECTIONS : int'(shadow_section_count);
    if (rq.operation == OP_WRITE) begin
      if (rq.entry_index < MAX_SECTIONS) shadow_table[rq.entry_index] = rq.entry;
      return 1'b0;
    end
    if (rq.operation == OP_NONE) return 1'b0;
    if (q == 33'd0) begin
      found = 1'b1;
    end else if (q <= {1'b0, shadow_header_size}) begin
      found = 1'b1;
      r     = q;
    end else begin
      // first matching entry wins
      for (i = 0; i < n && !found; i++) begin
        base = {1'b0, shadow_table[i].mem_address};
        off  = {1'b0, shadow_table[i].file_offset};
        span = (shadow_table[i].raw_size > shadow_table[i].virtual_size) ?
               {1'b0, shadow_table[i].raw_size} : {1'b0, shadow_table[i].virtual_size};
        top  = base + span;
        if (rq.operation == OP_MEM_TO_FILE) begin
          if (base <= q && q <= top) begin
            r     = off + (q - base);
            found = 1'b1;
          end
        end else if (off <= q && q <= off + {1'b0, shadow_table[i].raw_size}) begin
          r = base + (q - off);
          if (base <= r && r < top) found = 1'b1;
        end
      end
    end
    res.mapped_address = found ? r[ADDR_W-1:0] : '0;
    res.hit            = found;
    return 1'b1;
  endfunction

  function automatic sat_req_t mk_req(input logic [OP_W-1:0] op,
                                      input logic [ENTRY_IDX_W-1:0] idx,
                                      input sec_entry_t e, input logic [ADDR_W-1:0] q);
    sat_req_t rq;
    rq.operation     = op;
    rq.entry_index   = idx;
    rq.entry         = e;
    rq.query_address = q;
    return rq;
  endfunction

  function automatic logic [ADDR_W-1:0] draw_size();
    case ($urandom_range(7))
      0:       return '0;
      1:       return $urandom;
      2:       return '1;
      default: return $urandom_range(32'h1_0000);
    endcase
  endfunction

  // Random section, sometimes overlapping an existing one
  function automatic sec_entry_t draw_section_entry();
    sec_entry_t e;
    e.mem_address  = $urandom;
    e.virtual_size = draw_size();
    e.raw_size     = draw_size();
    e.file_offset  = $urandom;
    if ($urandom_range(3) == 0)
      e.mem_address = shadow_table[$urandom_range(MAX_SECTIONS-1)].mem_address + $urandom_range(255);
    if ($urandom_range(3) == 0)
      e.file_offset = shadow_table[$urandom_range(MAX_SECTIONS-1)].file_offset + $urandom_range(255);
    return e;
  endfunction

  // Mostly queries aimed at live windows and their edges; some writes and unused codes
  function automatic sat_req_t draw_request();
    sat_req_t          rq;
    sec_entry_t        e;
    logic [ADDR_W-1:0] base, lim;
    int                n, sel;
    rq = mk_req(OP_WRITE, ENTRY_IDX_W'($urandom_range(MAX_SECTIONS-1)),
                draw_section_entry(), $urandom);
    sel = $urandom_range(99);
    if (sel < 12) return rq;
    if (sel < 16) begin
      rq.operation = OP_NONE;
      return rq;
    end
    rq.operation = $urandom_range(1) ? OP_MEM_TO_FILE : OP_FILE_TO_MEM;
    n = (shadow_section_count > MAX_SECTIONS) ? MAX_SECTIONS : int'(shadow_section_count);
    e = shadow_table[$urandom_range(n > 0 ? n - 1 : MAX_SECTIONS - 1)];
    if (rq.operation == OP_MEM_TO_FILE) begin
      base = e.mem_address;
      lim  = (e.raw_size > e.virtual_size) ? e.raw_size : e.virtual_size;
    end else begin
      base = e.file_offset;
      lim  = e.raw_size;
    end
    case ($urandom_range(9))
      0: ;  // fully random address
      1: rq.query_address = (shadow_header_size == '1) ? $urandom :
                            $urandom_range(shadow_header_size + 32'd1);
      2: rq.query_address = base - 32'd1;
      3: rq.query_address = base + lim;
      4: rq.query_address = base + lim + 32'd1;
      5: rq.query_address = shadow_header_size + 32'd1;
      default: rq.query_address = base + $urandom_range(lim);
    endcase
    return rq;
  endfunction

  // One register write; the channel stays valid until the caller drops it
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_HEADER_SIZE) shadow_header_size = data;
    else if (idx == REG_SECTION_COUNT) shadow_section_count = data[COUNT_W-1:0];
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] header,
                              input logic [CFG_DATA_W-1:0] count_word, input bit stray);
    cfg_write(REG_HEADER_SIZE, header);
    cfg_write(REG_SECTION_COUNT, count_word);
    // unused register index must be ignored
    if (stray) cfg_write(CFG_IDX_W'($urandom_range(2, 15)), $urandom);
    @(negedge clk) cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || expected_translations.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Request acceptance: retire the offered request and predict its result
  logic in_hold = 1'b0;
  always @(posedge clk) begin
    sat_req_t    rq;
    sat_result_t res;
    in_hold = rst_n && in_ch.valid && !in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      rq = pending_reqs.pop_front();
      if (translate_request(rq, res)) expected_translations.push_back(res);
    end
  end

  // Request driver with random gap bursts
  int in_gap = 0;
  always @(negedge clk) begin
    if (!rst_n || in_hold) begin
      // hold the offered request until taken
    end else if (in_gap > 0) begin
      in_ch.valid <= 1'b0;
      in_gap--;
    end else if (pending_reqs.size() > 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      in_gap = $urandom_range(3);
    end else if (pending_reqs.size() > 0) begin
      in_ch.valid              <= 1'b1;
      in_ch.operation          <= pending_reqs[0].operation;
      in_ch.entry_index        <= pending_reqs[0].entry_index;
      in_ch.entry_mem_address  <= pending_reqs[0].entry.mem_address;
      in_ch.entry_virtual_size <= pending_reqs[0].entry.virtual_size;
      in_ch.entry_raw_size     <= pending_reqs[0].entry.raw_size;
      in_ch.entry_file_offset  <= pending_reqs[0].entry.file_offset;
      in_ch.query_address      <= pending_reqs[0].query_address;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Result receiver: random stall bursts plus an occasional long hold-off
  int out_gap = 0, hold_left = 0, holds_done = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else if (holds_done < long_hold_req) begin
      out_ch.ready <= 1'b0;
      holds_done++;
      hold_left = LONG_HOLD - 1;
    end else if (out_gap > 0) begin
      out_ch.ready <= 1'b0;
      out_gap--;
    end else if ($urandom_range(99) < idle_pct) begin
      out_ch.ready <= 1'b0;
      out_gap = $urandom_range(3);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    sat_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_translations.size() == 0) begin
        $error("unexpected result: mapped_address %h hit %b", out_ch.mapped_address, out_ch.hit);
        error_count++;
      end else begin
        want = expected_translations.pop_front();
        if (out_ch.mapped_address !== want.mapped_address) begin
          $error("mapped_address: expected %h, actual %h", want.mapped_address,
                 out_ch.mapped_address);
          error_count++;
        end
        if (out_ch.hit !== want.hit) begin
          $error("hit: expected %b, actual %b", want.hit, out_ch.hit);
          error_count++;
        end
      end
    end
  end

  // Watchdog on handshake activity
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Stimulus sequence
  initial begin
    int                    phase, k, cnt;
    logic [ADDR_W-1:0]     header;
    logic [CFG_DATA_W-1:0] count_word;
    in_ch.valid              = 1'b0;
    in_ch.operation          = OP_NONE;
    in_ch.entry_index        = '0;
    in_ch.entry_mem_address  = '0;
    in_ch.entry_virtual_size = '0;
    in_ch.entry_raw_size     = '0;
    in_ch.entry_file_offset  = '0;
    in_ch.query_address      = '0;
    out_ch.ready             = 1'b0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.index             = REG_HEADER_SIZE;
    cfg_ch.data              = '0;
    rst_n                    = 1'b0;
    shadow_header_size       = HEADER_SIZE_RESET;
    shadow_section_count     = SECTION_COUNT_RESET;
    for (k = 0; k < MAX_SECTIONS; k++) shadow_table[k] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: reset config (count zero), zero, header edge, miss, unused code
    idle_pct = 20;
    pending_reqs.push_back(mk_req(OP_MEM_TO_FILE, '0, '0, 32'd0));
    pending_reqs.push_back(mk_req(OP_FILE_TO_MEM, '0, '0, 32'd1024));
    pending_reqs.push_back(mk_req(OP_MEM_TO_FILE, '0, '0, 32'd1025));
    pending_reqs.push_back(mk_req(OP_NONE, '0, '0, 32'd5));
    // fill the whole table; fields are mem, virtual, raw, file offset
    pending_reqs.push_back(mk_req(OP_WRITE, 4'd0,
      '{32'h0000_1000, 32'h0000_2000, 32'h0000_1000, 32'h0000_0400}, '0));
    pending_reqs.push_back(mk_req(OP_WRITE, 4'd1,
      '{32'h0000_1800, 32'h0000_0100, 32'h0000_0800, 32'h0000_8000}, '0));
    pending_reqs.push_back(mk_req(OP_WRITE, 4'd2,
      '{32'h0001_0000, 32'h0000_0100, 32'h0000_0200, 32'hFFFF_FF00}, '0));
    pending_reqs.push_back(mk_req(OP_WRITE, 4'd3,
      '{32'hFFFF_F000, 32'h0000_2000, 32'h0000_2000, 32'h0002_0000}, '0));
    for (k = 4; k < MAX_SECTIONS; k++)
      pending_reqs.push_back(mk_req(OP_WRITE, ENTRY_IDX_W'(k), draw_section_entry(), '0));
    wait_idle();

    // Directed: full table search cases
    program_regs(32'h400, MAX_SECTIONS, 1'b0);
    pending_reqs.push_back(mk_req(OP_MEM_TO_FILE, '0, '0, 32'h0000_3000));  // inclusive end
    pending_reqs.push_back(mk_req(OP_MEM_TO_FILE, '0, '0, 32'h0000_1900));  // overlap, first wins
    pending_reqs.push_back(mk_req(OP_MEM_TO_FILE, '0, '0, 32'h0001_0150));  // sum past 32 bits
    pending_reqs.push_back(mk_req(OP_FILE_TO_MEM, '0, '0, 32'h0000_8800));  // exclusive end
    pending_reqs.push_back(mk_req(OP_FILE_TO_MEM, '0, '0, 32'h0002_1800));  // memory wraps
    pending_reqs.push_back(mk_req(OP_FILE_TO_MEM, '0, '0, 32'h0000_1400));
    wait_idle();

    // Random phases over a spread of header sizes and section counts
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      header = $urandom_range(32'h2000);
      case (phase)
        0:       begin header = '0; cnt = MAX_SECTIONS; end
        1:       begin header = '1; cnt = MAX_SECTIONS; end
        2:       cnt = 31;
        3:       cnt = 0;
        4:       cnt = 1;
        5:       cnt = MAX_SECTIONS + 1;
        default: cnt = $urandom_range(31);
      endcase
      count_word = {($urandom_range(1) ? 27'($urandom) : 27'd0), 5'(cnt)};
      program_regs(header, count_word, phase[0]);
      idle_pct = (phase == RANDOM_PHASES - 1 || phase % 4 == 1) ? 0 : 25;
      if (phase == 6) long_hold_req++;
      for (k = 0; k < PHASE_ITEMS; k++) pending_reqs.push_back(draw_request());
      wait_idle();
    end

    if (error_count == 0 && expected_translations.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: section_address_translator.f
hw/rtl/sat_pkg.sv
hw/rtl/sat_if.sv
hw/rtl/sat_datapath.sv
hw/rtl/sat_controller.sv
hw/rtl/section_address_translator.sv
dv/tb_top.sv
